/* src/tgr_pkg.sv */
// Shared types, constants and the 5x7 glyph table for the text cell glyph renderer.
// Used by the core, the port checker and the testbench.
package tgr_pkg;

    // Text geometry.
    localparam int TEXT_ROWS     = 4;
    localparam int CELLS_PER_ROW = 21;
    localparam int PIXEL_COLUMNS = 128;
    localparam int TEXT_LIMIT    = 96;
    localparam int CELL_WIDTH    = 6;
    localparam int GLYPH_WIDTH   = 5;
    localparam int GRID_SIZE     = TEXT_ROWS * CELLS_PER_ROW;
    localparam int GLYPH_COUNT   = 40;

    // Derived widths.
    localparam int ADDR_W  = $clog2(GRID_SIZE);
    localparam int ROW_W   = $clog2(TEXT_ROWS + 1);
    localparam int CELL_W  = $clog2(CELLS_PER_ROW + 1);
    localparam int TAKEN_W = $clog2(TEXT_LIMIT);
    localparam int COL_W   = 7;
    localparam int SUB_W   = $clog2(CELL_WIDTH);
    localparam int SLOT_W  = $clog2(GLYPH_COUNT);

    // Reciprocal of the cell width for the column-to-cell split.
    localparam int RECIP_SHIFT = 8;
    localparam int CELL_RECIP  = (1 << RECIP_SHIFT) / CELL_WIDTH + 1;
    localparam int PROD_W      = COL_W + RECIP_SHIFT - 2;

    typedef logic [7:0] t_byte;

    localparam t_byte SPACE_CODE   = 8'h20;
    localparam t_byte NEWLINE_CODE = 8'h0A;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } t_state;

    // Glyph columns, bit 0 is the top pixel: digits, letters, then : - . /
    localparam t_byte GLYPH_ROM [0:GLYPH_COUNT-1][0:GLYPH_WIDTH-1] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
        '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02}
    };

    // Returns one glyph column for a character; unsupported characters are blank.
    function automatic t_byte glyph_column(input t_byte code, input logic [SUB_W-1:0] sub);
        t_byte             c;
        logic [SLOT_W-1:0] slot;
        logic              hit;
        c    = code;
        slot = '0;
        hit  = 1'b1;
        // Lowercase folds to uppercase.
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h20;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            slot = SLOT_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            slot = SLOT_W'(c - 8'h41 + 8'd10);
        end else if (c == 8'h3A) begin
            slot = SLOT_W'(36);
        end else if (c == 8'h2D) begin
            slot = SLOT_W'(37);
        end else if (c == 8'h2E) begin
            slot = SLOT_W'(38);
        end else if (c == 8'h2F) begin
            slot = SLOT_W'(39);
        end else begin
            hit = 1'b0;
        end
        if (!hit || int'(sub) >= GLYPH_WIDTH) begin
            return 8'h00;
        end
        return GLYPH_ROM[slot][sub];
    endfunction

endpackage

/* src/text_cell_glyph_renderer_core.sv */
// Top level of the text cell glyph renderer: cursor, grid RAM and glyph lookup.
// Depends on tgr_pkg and tgr_ram.
//
//  Channel   Handshake             Payload
//  request   start, busy           i_operation, i_char_code, i_page, i_pixel_column
//  result    o_strobe (1 cycle)    o_column_byte, o_text_full
//
// Start, append and unused requests strobe their result in the cycle after
// acceptance. A read passes through the registered read port of the grid RAM
// and then the result register; busy is high for the cycle in which the RAM
// data is turned into a glyph column. Reset is synchronous and clears the grid
// through per-cell valid bits, so no clearing pass is needed. The receiver
// cannot stall; each result is shown for exactly one cycle.
module text_cell_glyph_renderer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_operation,
    input  logic [7:0]                 i_char_code,
    input  logic [1:0]                 i_page,
    input  logic [tgr_pkg::COL_W-1:0]  i_pixel_column,
    output logic                       o_strobe,
    output logic [7:0]                 o_column_byte,
    output logic                       o_text_full
);
    import tgr_pkg::*;

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic [TAKEN_W-1:0]  r_taken, n_taken;
    logic [GRID_SIZE-1:0] r_valid, n_valid;
    logic                r_strobe, n_strobe;
    t_byte               r_byte, n_byte;

    // Read stage registers.
    logic                r_blank;
    logic [SUB_W-1:0]    r_sub;
    logic                r_ent_valid;

    logic                accept;
    logic                full_now;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ROW_W-1:0]    row_wr;
    logic [CELL_W-1:0]   cell_wr;
    logic                row_over;

    logic [PROD_W-1:0]   col_prod;
    logic [CELL_W-1:0]   q0, q;
    logic [COL_W:0]      rem0, rem;
    logic                rd_blank;
    logic [ADDR_W-1:0]   rd_addr;
    t_byte               ram_rdata;
    t_byte               shown_code;

    assign accept   = start && !busy;
    assign full_now = (int'(r_row) >= TEXT_ROWS) || (int'(r_taken) >= TEXT_LIMIT - 1);

    // Split the pixel column into cell and sub-column by reciprocal multiply.
    always_comb begin
        col_prod = PROD_W'(i_pixel_column) * PROD_W'(CELL_RECIP);
        q0       = CELL_W'(col_prod >> RECIP_SHIFT);
        rem0     = (COL_W+1)'(i_pixel_column) - (COL_W+1)'(q0) * (COL_W+1)'(CELL_WIDTH);
        if (int'(rem0) >= CELL_WIDTH) begin
            q   = q0 + 1'b1;
            rem = rem0 - (COL_W+1)'(CELL_WIDTH);
        end else begin
            q   = q0;
            rem = rem0;
        end
        rd_blank = (int'(i_page) >= TEXT_ROWS) || (int'(i_pixel_column) >= PIXEL_COLUMNS)
                || (int'(q) >= CELLS_PER_ROW) || (int'(rem) >= GLYPH_WIDTH)
                || ((int'(q) + 1) * CELL_WIDTH > PIXEL_COLUMNS);
        rd_addr  = ADDR_W'(int'(i_page) * CELLS_PER_ROW + int'(q));
    end

    // Append target: wrap to the next row when the current row is full.
    always_comb begin
        row_over = int'(r_cell) >= CELLS_PER_ROW;
        row_wr   = row_over ? r_row + 1'b1 : r_row;
        cell_wr  = row_over ? '0 : r_cell;
        wr_addr  = ADDR_W'(int'(row_wr) * CELLS_PER_ROW + int'(cell_wr));
    end

    // Next state, cursor update and result selection.
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_cell   = r_cell;
        n_taken  = r_taken;
        n_valid  = r_valid;
        n_strobe = 1'b0;
        n_byte   = 8'h00;
        wr_en    = 1'b0;
        shown_code = r_ent_valid ? ram_rdata : SPACE_CODE;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_START: begin
                            n_row    = '0;
                            n_cell   = '0;
                            n_taken  = '0;
                            n_valid  = '0;
                            n_strobe = 1'b1;
                        end
                        OP_APPEND: begin
                            n_strobe = 1'b1;
                            if (i_char_code != 8'h00 && !full_now) begin
                                n_taken = r_taken + 1'b1;
                                if (i_char_code == NEWLINE_CODE) begin
                                    n_row  = r_row + 1'b1;
                                    n_cell = '0;
                                end else if (int'(row_wr) >= TEXT_ROWS) begin
                                    n_row  = row_wr;
                                    n_cell = '0;
                                end else begin
                                    n_row            = row_wr;
                                    n_cell           = cell_wr + 1'b1;
                                    wr_en            = 1'b1;
                                    n_valid[wr_addr] = 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            n_state = ST_RESP;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                n_strobe = 1'b1;
                n_byte   = r_blank ? 8'h00 : glyph_column(shown_code, r_sub);
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_cell   <= '0;
            r_taken  <= '0;
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_cell   <= n_cell;
            r_taken  <= n_taken;
            r_valid  <= n_valid;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (accept) begin
            r_blank     <= rd_blank;
            r_sub       <= rem[SUB_W-1:0];
            r_ent_valid <= rd_blank ? 1'b0 : r_valid[rd_addr];
        end
    end

    // Character grid storage.
    tgr_ram #(
        .WIDTH (8),
        .DEPTH (GRID_SIZE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_char_code),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign busy          = (r_state == ST_RESP) || !i_rst_n;
    assign o_strobe      = r_strobe;
    assign o_column_byte = r_byte;
    assign o_text_full   = full_now;

endmodule

/* src/tgr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 84
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tgr_checker.sv */
// Port-level checker for the text cell glyph renderer, bound to the top level.
// Depends on tgr_pkg.
module tgr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_strobe,
    input logic [7:0] o_column_byte,
    input logic       o_text_full
);
    import tgr_pkg::*;

    logic acc;
    assign acc = start && !busy;

    // A non-read request answers in the next cycle.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_operation != OP_READ |=> o_strobe)
        else $error("non-read request gave no result in the next cycle");

    // A read holds busy for one cycle, then answers.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_operation == OP_READ |=> busy && !o_strobe ##1 o_strobe)
        else $error("read request timing broken");

    // Busy never lasts more than one cycle.
    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // A start leaves the text empty and returns a zero byte.
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_operation == OP_START |=> !o_text_full && o_column_byte == 8'h00)
        else $error("start did not clear the text");

endmodule

bind text_cell_glyph_renderer_core tgr_checker u_tgr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .o_strobe      (o_strobe),
    .o_column_byte (o_column_byte),
    .o_text_full   (o_text_full)
);

/* verif/testbench.sv */
// Self-checking testbench for text_cell_glyph_renderer_core: a directed table, then
// random episodes, checked against a local model or fixed row results. Depends on tgr_pkg.
`timescale 1ns / 100ps

module testbench;
    import tgr_pkg::*;

    localparam int ITEM_TOTAL  = 1200;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;

    // One expected result of a request.
    typedef struct {
        logic [7:0] col_byte;
        logic       full;
    } t_column_result;

    // One row of the directed table; fixed rows carry their expected result.
    typedef struct {
        t_op        op;
        logic [7:0] code;
        logic [1:0] pg;
        logic [6:0] col;
        bit         fixed;
        logic [7:0] col_byte;
        bit         full;
    } t_text_step;

    // Glyph columns: digits, letters, then : - . /
    localparam logic [7:0] FONT_5X7 [200] = '{
        8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
        8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
        8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
        8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,  8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,
        8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
        8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A,  8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
        8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,  8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
        8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,  8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,  8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
        8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,  8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
        8'h46, 8'h49, 8'h49, 8'h49, 8'h31,  8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
        8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,  8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
        8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,  8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
        8'h07, 8'h08, 8'h70, 8'h08, 8'h07,  8'h61, 8'h51, 8'h49, 8'h45, 8'h43,
        8'h00, 8'h36, 8'h36, 8'h00, 8'h00,  8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
        8'h00, 8'h60, 8'h60, 8'h00, 8'h00,  8'h20, 8'h10, 8'h08, 8'h04, 8'h02
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_operation;
    logic [7:0] i_char_code;
    logic [1:0] i_page;
    logic [6:0] i_pixel_column;
    logic       o_strobe;
    logic [7:0] o_column_byte;
    logic       o_text_full;

    // Local copy of the text state.
    logic [7:0] text_cells [GRID_SIZE];
    int         cur_row;
    int         cur_cell;
    int         taken_count;

    t_column_result expected_columns [$];
    int             mismatches;
    int             sent_requests;
    int             cycle_count;
    t_text_step     directed_steps [28];

    text_cell_glyph_renderer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_char_code    (i_char_code),
        .i_page         (i_page),
        .i_pixel_column (i_pixel_column),
        .o_strobe       (o_strobe),
        .o_column_byte  (o_column_byte),
        .o_text_full    (o_text_full)
    );

    // 12 ns clock.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit text_full_now();
        return cur_row >= TEXT_ROWS || taken_count >= TEXT_LIMIT - 1;
    endfunction

    function automatic void clear_text();
        foreach (text_cells[n]) text_cells[n] = SPACE_CODE;
        cur_row     = 0;
        cur_cell    = 0;
        taken_count = 0;
    endfunction

    // Column bits of one character; folds lowercase, blank where there is no glyph.
    function automatic logic [7:0] font_bits(input logic [7:0] code, input int sub);
        logic [7:0] c;
        int         slot;
        c    = code;
        slot = -1;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        if (c >= 8'h30 && c <= 8'h39) slot = int'(c) - 'h30;
        else if (c >= 8'h41 && c <= 8'h5A) slot = int'(c) - 'h41 + 10;
        else if (c == 8'h3A) slot = 36;
        else if (c == 8'h2D) slot = 37;
        else if (c == 8'h2E) slot = 38;
        else if (c == 8'h2F) slot = 39;
        if (slot < 0 || sub >= GLYPH_WIDTH) return 8'h00;
        return FONT_5X7[slot * GLYPH_WIDTH + sub];
    endfunction

    // Cursor update for one appended character.
    function automatic void append_char(input logic [7:0] code);
        if (code == 8'h00 || text_full_now()) return;
        taken_count++;
        if (code == NEWLINE_CODE) begin
            cur_row++;
            cur_cell = 0;
            return;
        end
        // A full row wraps before the character is placed.
        if (cur_cell >= CELLS_PER_ROW) begin
            cur_row++;
            cur_cell = 0;
            if (cur_row >= TEXT_ROWS) return;
        end
        text_cells[cur_row * CELLS_PER_ROW + cur_cell] = code;
        cur_cell++;
    endfunction

    function automatic logic [7:0] read_column(input int pg, input int col);
        int cell_idx;
        int sub;
        if (pg >= TEXT_ROWS || col >= PIXEL_COLUMNS) return 8'h00;
        cell_idx = col / CELL_WIDTH;
        sub      = col % CELL_WIDTH;
        if (cell_idx >= CELLS_PER_ROW || sub >= GLYPH_WIDTH) return 8'h00;
        if ((cell_idx + 1) * CELL_WIDTH > PIXEL_COLUMNS) return 8'h00;
        return font_bits(text_cells[pg * CELLS_PER_ROW + cell_idx], sub);
    endfunction

    // Expected result of one request; updates the local text state.
    function automatic t_column_result render_request(input t_op op, input logic [7:0] code,
                                                      input logic [1:0] pg,
                                                      input logic [6:0] col);
        t_column_result res;
        res.col_byte = 8'h00;
        case (op)
            OP_START:  clear_text();
            OP_APPEND: append_char(code);
            OP_READ:   res.col_byte = read_column(int'(pg), int'(col));
            default:   ;
        endcase
        res.full = text_full_now();
        return res;
    endfunction

    // Character stream for appends: mostly glyphs, some newlines, nulls and noise.
    function automatic logic [7:0] pick_char(input int newline_pct);
        int r;
        if ($urandom_range(0, 99) < newline_pct) return NEWLINE_CODE;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'($urandom_range('h41, 'h5A));
        if (r < 60) return 8'($urandom_range('h61, 'h7A));
        if (r < 75) return 8'($urandom_range('h30, 'h39));
        if (r < 82) return 8'h2D + 8'($urandom_range(0, 2)) + (r[0] ? 8'h00 : 8'h0D);
        if (r < 86) return 8'h00;
        if (r < 91) return SPACE_CODE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Present one request and hold it until accepted, then queue its expected result.
    task automatic issue_request(input t_op op, input logic [7:0] code, input logic [1:0] pg,
                                 input logic [6:0] col, input bit fixed,
                                 input logic [7:0] fixed_byte, input bit fixed_full);
        t_column_result res;
        start          <= 1'b1;
        i_operation    <= op;
        i_char_code    <= code;
        i_page         <= pg;
        i_pixel_column <= col;
        @(posedge i_clk);
        while (busy === 1'b1) @(posedge i_clk);
        res = render_request(op, code, pg, col);
        if (fixed) begin
            res.col_byte = fixed_byte;
            res.full     = fixed_full;
        end
        expected_columns.push_back(res);
        sent_requests++;
    endtask

    // Random sender gap, off for the tail of the run.
    task automatic sender_gap();
        if (sent_requests < ITEM_TOTAL - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_columns.size() != 0) @(posedge i_clk);
    endtask

    // Result checker.
    always @(posedge i_clk) begin : check_results
        t_column_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_columns.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: byte %02h full %b", o_column_byte,
                             o_text_full);
                mismatches++;
            end else begin
                want = expected_columns.pop_front();
                if (o_column_byte !== want.col_byte || o_text_full !== want.full) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: expected byte %02h full %b, got byte %02h full %b",
                                 want.col_byte, want.full, o_column_byte, o_text_full);
                    mismatches++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int         newline_pct;
        int         episode_len;
        int         r;
        int         waited;
        bit         drained_once;
        t_op        op;
        logic [7:0] code;

        mismatches      = 0;
        sent_requests   = 0;
        cycle_count     = 0;
        drained_once    = 1'b0;
        clear_text();

        start          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_operation    <= OP_NONE;
        i_char_code    <= 8'h00;
        i_page         <= 2'd0;
        i_pixel_column <= 7'd0;

        // Directed requests: extremes, every operation, folding, blanks and overflow.
        directed_steps = '{
            '{OP_READ,   8'h00, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_NONE,   8'hFF, 2'd3, 7'd127, 1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'h30, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd0,   1'b1, 8'h3E, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd4,   1'b1, 8'h3E, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd5,   1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'h61, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd6,   1'b1, 8'h7E, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd10,  1'b1, 8'h7E, 1'b0},
            '{OP_APPEND, 8'h00, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd12,  1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'hFF, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd12,  1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'h0A, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'h5A, 2'd0, 7'd0,   1'b0, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd1, 7'd0,   1'b0, 8'h00, 1'b0},
            '{OP_APPEND, 8'h2F, 2'd0, 7'd0,   1'b0, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd1, 7'd7,   1'b0, 8'h00, 1'b0},
            '{OP_READ,   8'hFF, 2'd3, 7'd127, 1'b1, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd126, 1'b1, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd0, 7'd125, 1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'h0A, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'h0A, 2'd0, 7'd0,   1'b1, 8'h00, 1'b0},
            '{OP_APPEND, 8'h0A, 2'd0, 7'd0,   1'b1, 8'h00, 1'b1},
            '{OP_APPEND, 8'h41, 2'd0, 7'd0,   1'b1, 8'h00, 1'b1},
            '{OP_READ,   8'h00, 2'd1, 7'd0,   1'b0, 8'h00, 1'b0},
            '{OP_START,  8'hFF, 2'd3, 7'd127, 1'b1, 8'h00, 1'b0},
            '{OP_READ,   8'h00, 2'd1, 7'd0,   1'b1, 8'h00, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[n]) begin
            sender_gap();
            issue_request(directed_steps[n].op, directed_steps[n].code, directed_steps[n].pg,
                          directed_steps[n].col, directed_steps[n].fixed,
                          directed_steps[n].col_byte, directed_steps[n].full);
        end

        // Random text episodes: a start, then appends with reads and stray requests mixed in.
        while (sent_requests < ITEM_TOTAL) begin
            r = $urandom_range(0, 2);
            newline_pct = (r == 0) ? 0 : ((r == 1) ? 4 : 20);
            episode_len = $urandom_range(30, 220);
            if (!drained_once && sent_requests >= ITEM_TOTAL / 2) begin
                wait_for_results();
                drained_once = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                wait_for_results();
            end
            sender_gap();
            issue_request(OP_START, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          7'($urandom_range(0, 127)), 1'b0, 8'h00, 1'b0);
            for (int k = 0; k < episode_len && sent_requests < ITEM_TOTAL; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55) op = OP_APPEND;
                else if (r < 94) op = OP_READ;
                else if (r < 98) op = OP_NONE;
                else op = OP_START;
                code = (op == OP_APPEND) ? pick_char(newline_pct) : 8'($urandom_range(0, 255));
                sender_gap();
                issue_request(op, code, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                              1'b0, 8'h00, 1'b0);
            end
        end

        // Drain outstanding results, then let the pipeline settle.
        start <= 1'b0;
        waited = 0;
        while (expected_columns.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_columns.size() != 0) begin
            $display("%0d results never arrived", expected_columns.size());
            mismatches += expected_columns.size();
        end

        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
